FILE: src/pmf_pkg.sv
package pmf_pkg;

	// Data word and fraction defaults
	localparam int WORD_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int LANES         = 3;

	// Configuration port
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGNET_X        = 3'd0,
		CFG_MAGNET_Y        = 3'd1,
		CFG_MAGNET_Z        = 3'd2,
		CFG_MAGNET_STRENGTH = 3'd3,
		CFG_CAPTURE_RADIUS  = 3'd4,
		CFG_TIME_STEP       = 3'd5
	} cfg_idx_t;

	// Result zone codes
	typedef enum logic [1:0] {
		ZONE_CENTER  = 2'd0,
		ZONE_ATTRACT = 2'd1,
		ZONE_DAMP    = 2'd2
	} zone_t;

	// Attraction quotient: N = |strength|*dt*|d| < 2^93, divided by 1000*S.
	// The quotient is clamped at 2^50 before the divide by 1000.
	localparam int ATT_N_W    = 93;
	localparam int ATT_DEN_W  = 74;
	localparam int ATT_Q_W    = 41;
	localparam int CLAMP_SH   = 50;
	localparam logic [ATT_Q_W-1:0] F_CLAMP = 41'd1125899906842;

	// Square root of a 64 bit sum, one result bit per stage
	localparam int SQRT_STEPS = 32;

	// Damping quotient |vel|*2^F / (2^F + sqrt(S))
	localparam int DAMP_Q_W   = 32;
	localparam int DAMP_DEN_W = 33;

	typedef struct packed {
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] pos_z;
		logic signed [WORD_W-1:0] vel_x;
		logic signed [WORD_W-1:0] vel_y;
		logic signed [WORD_W-1:0] vel_z;
	} item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] new_vel_x;
		logic signed [WORD_W-1:0] new_vel_y;
		logic signed [WORD_W-1:0] new_vel_z;
		zone_t                    zone;
	} result_t;

endpackage

FILE: src/pmf_div.sv
module pmf_div #(
	parameter int QW = 32,
	parameter int DW = 33
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_in,
	input  logic [QW-1:0] nq_in,
	input  logic [DW-1:0] den_in,
	output logic [QW-1:0] quo
);

	// Restoring division, one quotient bit per stage.
	// nq shifts dividend bits out at the top and quotient bits in at the bottom.
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] nq_s  [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_prev;
		logic [QW-1:0] nq_prev;
		logic [DW-1:0] den_prev;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_prev = rem_in;
			assign nq_prev  = nq_in;
			assign den_prev = den_in;
		end else begin : g_next
			assign rem_prev = rem_s[k-1];
			assign nq_prev  = nq_s[k-1];
			assign den_prev = den_s[k-1];
		end

		assign trial = {rem_prev, nq_prev[QW-1]};
		assign ge    = trial >= {1'b0, den_prev};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
				nq_s[k]  <= {nq_prev[QW-2:0], ge};
				den_s[k] <= den_prev;
			end
		end
	end

	assign quo = nq_s[QW-1];

endmodule

FILE: src/pmf_isqrt.sv
module pmf_isqrt #(
	parameter int STEPS = 32
) (
	input  logic               clk,
	input  logic               en,
	input  logic [2*STEPS-1:0] s_in,
	output logic [STEPS-1:0]   root
);

	localparam int W = 2 * STEPS;

	// Digit-by-digit square root, one root bit per stage
	logic [W-1:0] rem_s [STEPS];
	logic [W-1:0] res_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		localparam int SH = 2 * (STEPS - 1 - k);
		logic [W-1:0] rem_prev;
		logic [W-1:0] res_prev;
		logic [W-1:0] trial;
		logic         take;

		if (k == 0) begin : g_first
			assign rem_prev = s_in;
			assign res_prev = '0;
		end else begin : g_next
			assign rem_prev = rem_s[k-1];
			assign res_prev = res_s[k-1];
		end

		assign trial = res_prev + (W'(1) << SH);
		assign take  = rem_prev >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? rem_prev - trial : rem_prev;
				res_s[k] <= take ? (res_prev >> 1) + (W'(1) << SH) : res_prev >> 1;
			end
		end
	end

	assign root = res_s[STEPS-1][STEPS-1:0];

endmodule

FILE: src/particle_point_magnet_force.sv
// Point-magnet force pipeline, one particle per transaction.
// Accepts one item per cycle while item_stall is low (output buffer not full); depth
// is set by the 32 stage square root followed by the 32 stage damping divider.
// A two-entry output buffer decouples the result side from the pipeline.
// Reset (arst_n low) clears valid bits and the buffer; config registers go to 0, dt to 1.0.
module particle_point_magnet_force #(
	parameter int FRAC_BITS = pmf_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  pmf_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output pmf_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pmf_pkg::WORD_W-1:0]    cfg_data
);
	import pmf_pkg::*;

	localparam int PROD_W    = 63;
	localparam int VD_W      = PROD_W - FRAC_BITS;
	localparam int OFS_W     = VD_W + 2;
	localparam int ENTRY     = 5;
	localparam int SQRT_LAST = ENTRY - 1 + SQRT_STEPS;
	localparam int LAST      = SQRT_LAST + DAMP_Q_W;
	localparam int ATT_LAST  = ENTRY + ATT_Q_W;
	localparam int SIDE_N    = LAST - ENTRY + 1;
	localparam int ATT_DLY   = LAST - ATT_LAST;

	typedef struct packed {
		logic [LANES-1:0][WORD_W-1:0] vel;
		logic [LANES-1:0]             fneg;
		logic [LANES-1:0]             ovf;
		zone_t                        zone;
	} side_t;

	// Configuration registers
	logic signed [WORD_W-1:0] mag_x_q, mag_y_q, mag_z_q, strength_q;
	logic [30:0]              radius_q, dt_q;
	logic [61:0]              sdt_q, rsq_q;
	logic [WORD_W-1:0]        str_mag;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_x_q    <= '0;
			mag_y_q    <= '0;
			mag_z_q    <= '0;
			strength_q <= '0;
			radius_q   <= '0;
			dt_q       <= 31'(1) << FRAC_BITS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAGNET_X:        mag_x_q    <= cfg_data;
				CFG_MAGNET_Y:        mag_y_q    <= cfg_data;
				CFG_MAGNET_Z:        mag_z_q    <= cfg_data;
				CFG_MAGNET_STRENGTH: strength_q <= cfg_data;
				CFG_CAPTURE_RADIUS:  radius_q   <= cfg_data[30:0];
				CFG_TIME_STEP:       dt_q       <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Products of config only, settled long before an item needs them
	assign str_mag = strength_q[WORD_W-1] ? 32'(~strength_q) + 32'd1 : 32'(strength_q);

	always_ff @(posedge clk) begin
		sdt_q <= 62'(str_mag) * 62'(dt_q);
		rsq_q <= 62'(radius_q) * 62'(radius_q);
	end

	// Pipeline advance and valid bits
	logic            en;
	logic [1:0]      cnt_q;
	logic [LAST:1]   vld_s;

	assign en         = (cnt_q != 2'd2);
	assign item_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:1], item_valid};
		end
	end

	// Stage 1: |vel|*dt and magnet - pos
	logic signed [WORD_W-1:0] pos_in [LANES];
	logic signed [WORD_W-1:0] vel_in [LANES];
	logic signed [WORD_W-1:0] mag    [LANES];
	logic [WORD_W-1:0]        vmag_c [LANES];
	logic [PROD_W-1:0]        vprod_s1 [LANES];
	logic signed [WORD_W:0]   mp_s1    [LANES];
	logic signed [WORD_W-1:0] vel_s1   [LANES];

	assign pos_in[0] = item.pos_x;
	assign pos_in[1] = item.pos_y;
	assign pos_in[2] = item.pos_z;
	assign vel_in[0] = item.vel_x;
	assign vel_in[1] = item.vel_y;
	assign vel_in[2] = item.vel_z;
	assign mag[0]    = mag_x_q;
	assign mag[1]    = mag_y_q;
	assign mag[2]    = mag_z_q;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			vmag_c[i] = vel_in[i][WORD_W-1] ? 32'(~vel_in[i]) + 32'd1 : 32'(vel_in[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				vprod_s1[i] <= PROD_W'(vmag_c[i]) * PROD_W'(dt_q);
				mp_s1[i]    <= 33'(mag[i]) - 33'(pos_in[i]);
				vel_s1[i]   <= vel_in[i];
			end
		end
	end

	// Stage 2: saturated offset d
	logic signed [OFS_W-1:0]  ofs_c [LANES];
	logic signed [WORD_W-1:0] d_s2   [LANES];
	logic signed [WORD_W-1:0] vel_s2 [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ofs_c[i] = vel_s1[i][WORD_W-1]
				? OFS_W'(mp_s1[i]) - $signed({2'b00, vprod_s1[i][PROD_W-1:FRAC_BITS]})
				: OFS_W'(mp_s1[i]) + $signed({2'b00, vprod_s1[i][PROD_W-1:FRAC_BITS]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				if ((ofs_c[i][OFS_W-1:31] == '0) || (ofs_c[i][OFS_W-1:31] == '1)) begin
					d_s2[i] <= ofs_c[i][31:0];
				end else begin
					d_s2[i] <= ofs_c[i][OFS_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				end
				vel_s2[i] <= vel_s1[i];
			end
		end
	end

	// Stage 3: squares and force numerator partial products
	logic [WORD_W-1:0]        dmag_c [LANES];
	logic [62:0]              sq_s3  [LANES];
	logic [63:0]              plo_s3 [LANES];
	logic [61:0]              phi_s3 [LANES];
	logic [LANES-1:0]         fneg_s3;
	logic signed [WORD_W-1:0] vel_s3 [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			dmag_c[i] = d_s2[i][WORD_W-1] ? 32'(~d_s2[i]) + 32'd1 : 32'(d_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				sq_s3[i]   <= 63'(dmag_c[i]) * 63'(dmag_c[i]);
				plo_s3[i]  <= 64'(sdt_q[31:0]) * 64'(dmag_c[i]);
				phi_s3[i]  <= 62'(sdt_q[61:32]) * 62'(dmag_c[i]);
				fneg_s3[i] <= strength_q[WORD_W-1] ^ d_s2[i][WORD_W-1];
				vel_s3[i]  <= vel_s2[i];
			end
		end
	end

	// Stage 4: squared length S and full numerators
	logic [63:0]              s_s4;
	logic [ATT_N_W-1:0]       n_s4 [LANES];
	logic [LANES-1:0]         fneg_s4;
	logic signed [WORD_W-1:0] vel_s4 [LANES];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s4 <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);
			for (int i = 0; i < LANES; i++) begin
				n_s4[i]   <= (ATT_N_W'(phi_s3[i]) << 32) + ATT_N_W'(plo_s3[i]);
				vel_s4[i] <= vel_s3[i];
			end
			fneg_s4 <= fneg_s3;
		end
	end

	// Stage 5: zone, clamp test, divider setup
	side_t                side_c;
	logic [ATT_DEN_W-1:0] att_den_s5;
	logic [ATT_DEN_W-1:0] att_rem_s5 [LANES];
	logic [ATT_Q_W-1:0]   att_nq_s5  [LANES];
	side_t                side_s [SIDE_N];

	always_comb begin
		if (s_s4 == '0) begin
			side_c.zone = ZONE_CENTER;
		end else if (s_s4 > 64'(rsq_q)) begin
			side_c.zone = ZONE_ATTRACT;
		end else begin
			side_c.zone = ZONE_DAMP;
		end
		for (int i = 0; i < LANES; i++) begin
			side_c.vel[i]  = vel_s4[i];
			side_c.fneg[i] = fneg_s4[i];
			side_c.ovf[i]  = 64'(n_s4[i][ATT_N_W-1:CLAMP_SH]) >= s_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			att_den_s5 <= (ATT_DEN_W'(s_s4) << 10) - (ATT_DEN_W'(s_s4) << 4)
				- (ATT_DEN_W'(s_s4) << 3);
			for (int i = 0; i < LANES; i++) begin
				att_rem_s5[i] <= ATT_DEN_W'(n_s4[i][ATT_N_W-1:ATT_Q_W]);
				att_nq_s5[i]  <= n_s4[i][ATT_Q_W-1:0];
			end
			side_s[0] <= side_c;
			for (int j = 1; j < SIDE_N; j++) begin
				side_s[j] <= side_s[j-1];
			end
		end
	end

	// Square root of S, in parallel with the attraction dividers
	logic [SQRT_STEPS-1:0] root;

	pmf_isqrt #(.STEPS(SQRT_STEPS)) u_isqrt (
		.clk  (clk),
		.en   (en),
		.s_in (s_s4),
		.root (root)
	);

	// Damping divider setup from the root
	logic [DAMP_DEN_W-1:0] damp_den_c;
	logic [DAMP_DEN_W-1:0] damp_rem_c [LANES];
	logic [DAMP_Q_W-1:0]   damp_nq_c  [LANES];
	logic [WORD_W-1:0]     dvm_c      [LANES];
	side_t                 side_mid;

	assign side_mid   = side_s[SQRT_LAST-ENTRY];
	assign damp_den_c = (DAMP_DEN_W'(1) << FRAC_BITS) + DAMP_DEN_W'(root);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			dvm_c[i] = side_mid.vel[i][WORD_W-1] ? ~side_mid.vel[i] + 32'd1
				: side_mid.vel[i];
			damp_rem_c[i] = DAMP_DEN_W'(dvm_c[i] >> (WORD_W - FRAC_BITS));
			damp_nq_c[i]  = dvm_c[i] << FRAC_BITS;
		end
	end

	// Per-lane dividers
	logic [ATT_Q_W-1:0]  att_quo  [LANES];
	logic [DAMP_Q_W-1:0] damp_quo [LANES];

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		pmf_div #(.QW(ATT_Q_W), .DW(ATT_DEN_W)) u_att_div (
			.clk    (clk),
			.en     (en),
			.rem_in (att_rem_s5[g]),
			.nq_in  (att_nq_s5[g]),
			.den_in (att_den_s5),
			.quo    (att_quo[g])
		);

		pmf_div #(.QW(DAMP_Q_W), .DW(DAMP_DEN_W)) u_damp_div (
			.clk    (clk),
			.en     (en),
			.rem_in (damp_rem_c[g]),
			.nq_in  (damp_nq_c[g]),
			.den_in (damp_den_c),
			.quo    (damp_quo[g])
		);
	end

	// Clamp the attraction term and hold it until the damping result arrives
	side_t              side_att;
	logic [ATT_Q_W-1:0] attd_s [ATT_DLY][LANES];

	assign side_att = side_s[ATT_LAST-ENTRY];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				attd_s[0][i] <= side_att.ovf[i] ? F_CLAMP : att_quo[i];
			end
			for (int j = 1; j < ATT_DLY; j++) begin
				attd_s[j] <= attd_s[j-1];
			end
		end
	end

	// Final select and saturate
	side_t                    side_end;
	logic signed [42:0]       asum_c [LANES];
	logic signed [WORD_W-1:0] nv_c   [LANES];
	result_t                  res_c;

	assign side_end = side_s[SIDE_N-1];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			asum_c[i] = side_end.fneg[i]
				? 43'($signed(side_end.vel[i])) - $signed({2'b00, attd_s[ATT_DLY-1][i]})
				: 43'($signed(side_end.vel[i])) + $signed({2'b00, attd_s[ATT_DLY-1][i]});
			case (side_end.zone)
				ZONE_ATTRACT: begin
					if ((asum_c[i][42:31] == '0) || (asum_c[i][42:31] == '1)) begin
						nv_c[i] = asum_c[i][31:0];
					end else begin
						nv_c[i] = asum_c[i][42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					end
				end
				ZONE_DAMP: begin
					nv_c[i] = side_end.vel[i][WORD_W-1] ? 32'(~damp_quo[i]) + 32'd1
						: 32'(damp_quo[i]);
				end
				default: nv_c[i] = side_end.vel[i];
			endcase
		end
		res_c.new_vel_x = nv_c[0];
		res_c.new_vel_y = nv_c[1];
		res_c.new_vel_z = nv_c[2];
		res_c.zone      = side_end.zone;
	end

	// Two-entry output buffer
	logic    push, pop;
	result_t data0_q, data1_q;

	assign push         = en && vld_s[LAST];
	assign result_valid = (cnt_q != 2'd0);
	assign pop          = result_valid && !result_stall;
	assign result       = data0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				data0_q <= res_c;
			end else begin
				data1_q <= res_c;
			end
		end else if (pop && !push) begin
			data0_q <= data1_q;
		end else if (push && pop) begin
			if (cnt_q == 2'd1) begin
				data0_q <= res_c;
			end else begin
				data0_q <= data1_q;
				data1_q <= res_c;
			end
		end
	end

endmodule

FILE: src/pmf_checker.sv
module pmf_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input pmf_pkg::result_t result
);
	import pmf_pkg::*;

	// A stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Input back-pressure only while results are buffered
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with empty output buffer");

	// Buffer fills only after the result side held off a transaction
	a_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(result_valid && result_stall))
		else $error("output buffer filled without result stall");

	// An empty buffer cannot be full in the next cycle
	a_no_jump: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |=> !item_stall)
		else $error("output buffer filled too fast");

endmodule

bind particle_point_magnet_force pmf_checker u_pmf_checker (.*);
